### design/bpq_pkg.sv
package bpq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int MAX_DEPTH     = 256;
    localparam int PTR_W         = $clog2(MAX_DEPTH);

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] push_value;
        logic signed [31:0] push_priority;
    } bpq_in_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] popped_value;
        logic signed [31:0] popped_priority;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } bpq_out_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_ROTATE = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [PTR_W-1:0] ptr;
    } cell_ctrl_t;

endpackage

### design/bpq_cell.sv
module bpq_cell (
    input  logic                     clk,
    input  bpq_pkg::cell_ctrl_t      ctrl,
    input  logic [bpq_pkg::PTR_W-1:0] idx,
    input  bpq_pkg::entry_t          nb_entry,
    input  bpq_pkg::entry_t          push_entry,
    output bpq_pkg::entry_t          entry
);
    import bpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_LOAD:
            begin
                if (idx == ctrl.ptr)
                begin
                    entry_next = push_entry;
                end
            end
            CELL_ROTATE:
            begin
                entry_next = nb_entry;
            end
            CELL_REMOVE:
            begin
                // close the gap behind the removed entry
                if (idx >= ctrl.ptr)
                begin
                    entry_next = nb_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### design/bounded_priority_queue.sv
// An accepted item is handled in ST_IDLE; a pop on a non-empty queue then passes
// through ST_SCAN and ST_REMOVE, and every result waits in ST_DONE for the output register.
// The block takes no new item (in_stall) until the last result is handed over; a pop
// rotates the whole cell chain once past the head cell to find the best entry.
// Reset (rst_n, async, active low) empties the queue, sets capacity to 16 and
// drops any pending result.
module bounded_priority_queue #(
    parameter int DEPTH = bpq_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bpq_pkg::bpq_in_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output bpq_pkg::bpq_out_t out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import bpq_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = (FW > 5) ? FW : 5;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_REMOVE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [IW-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [4:0]        capacity_reg;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    entry_t            best_reg, best_next;
    bpq_out_t          res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    bpq_out_t          out_item_reg, out_item_next;

    logic [CW-1:0]     eff_cap;
    logic              push_ok;
    logic              take;
    cell_ctrl_t        cell_ctrl;
    entry_t            push_entry;
    entry_t            cell_q [DEPTH];

    function automatic bpq_out_t make_result(
        input logic               ok,
        input logic signed [31:0] v,
        input logic signed [31:0] p,
        input logic [FW-1:0]      f,
        input logic [CW-1:0]      cap
    );
        bpq_out_t r;
        r.ok              = ok;
        r.popped_value    = v;
        r.popped_priority = p;
        r.entry_count     = 5'(f);
        r.is_empty        = (f == '0);
        r.is_full         = (CW'(f) >= cap);
        return r;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[4:0];
        end
    end

    // clamp capacity to 1..DEPTH
    always_comb
    begin
        if (capacity_reg == 5'd0)
        begin
            eff_cap = CW'(1);
        end
        else if (CW'(capacity_reg) > CW'(DEPTH))
        begin
            eff_cap = CW'(DEPTH);
        end
        else
        begin
            eff_cap = CW'(capacity_reg);
        end
    end

    assign push_ok          = (CW'(fill_reg) < eff_cap);
    assign in_stall         = (state_reg != ST_IDLE);
    assign push_entry.value = in_item.push_value;
    assign push_entry.prio  = in_item.push_priority;

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t nb;
            if (gi == DEPTH - 1)
            begin : g_wrap
                assign nb = cell_q[0];
            end
            else
            begin : g_link
                assign nb = cell_q[gi + 1];
            end
            bpq_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .idx        (PTR_W'(gi)),
                .nb_entry   (nb),
                .push_entry (push_entry),
                .entry      (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        cell_ctrl.op  = CELL_HOLD;
        cell_ctrl.ptr = PTR_W'(fill_reg);
        priority case (1'b1)
            (state_reg == ST_IDLE) && in_valid && (in_item.opcode == OP_PUSH) && push_ok:
            begin
                cell_ctrl.op  = CELL_LOAD;
                cell_ctrl.ptr = PTR_W'(fill_reg);
            end
            (state_reg == ST_SCAN):
            begin
                cell_ctrl.op = CELL_ROTATE;
            end
            (state_reg == ST_REMOVE):
            begin
                cell_ctrl.op  = CELL_REMOVE;
                cell_ctrl.ptr = PTR_W'(best_idx_reg);
            end
            default:
            begin
                cell_ctrl.op = CELL_HOLD;
            end
        endcase
    end

    // head cell holds entry scan_cnt during the scan; earliest wins on ties
    assign take = (FW'(scan_cnt_reg) < fill_reg)
                  && ((scan_cnt_reg == '0) || (cell_q[0].prio > best_reg.prio));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_cnt_next  = scan_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DONE;
                    priority case (1'b1)
                        (in_item.opcode == OP_PUSH):
                        begin
                            if (push_ok)
                            begin
                                fill_next = fill_reg + FW'(1);
                                res_next  = make_result(1'b1, '0, '0,
                                                        fill_reg + FW'(1), eff_cap);
                            end
                            else
                            begin
                                res_next = make_result(1'b0, '0, '0, fill_reg, eff_cap);
                            end
                        end
                        (in_item.opcode == OP_POP):
                        begin
                            if (fill_reg != '0)
                            begin
                                state_next    = ST_SCAN;
                                scan_cnt_next = '0;
                            end
                            else
                            begin
                                res_next = make_result(1'b0, '0, '0, fill_reg, eff_cap);
                            end
                        end
                        (in_item.opcode == OP_CLEAR):
                        begin
                            fill_next = '0;
                            res_next  = make_result(1'b1, '0, '0, '0, eff_cap);
                        end
                        default:
                        begin
                            res_next = make_result(1'b0, '0, '0, fill_reg, eff_cap);
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    best_next     = cell_q[0];
                    best_idx_next = scan_cnt_reg;
                end
                if (scan_cnt_reg == IW'(DEPTH - 1))
                begin
                    scan_cnt_next = '0;
                    state_next    = ST_REMOVE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + IW'(1);
                end
            end
            ST_REMOVE:
            begin
                fill_next  = fill_reg - FW'(1);
                res_next   = make_result(1'b1, best_reg.value, best_reg.prio,
                                         fill_reg - FW'(1), eff_cap);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill level above depth");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (scan_cnt_reg == IW'(DEPTH - 1)) |=> state_reg == ST_REMOVE)
        else $error("scan did not end after one full rotation");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE) |=> fill_reg == $past(fill_reg) - FW'(1))
        else $error("pop did not drop one entry");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.is_empty == (out_item.entry_count == 5'd0)))
        else $error("empty flag disagrees with entry count");
`endif

endmodule

### dv/bounded_priority_queue_tb.sv
module bounded_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpq_pkg::*;

    localparam int         DEPTH      = DEPTH_DEFAULT;
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] CAP_ADDR   = 3'd0;
    localparam logic [2:0] SPARE_ADDR = 3'd4;
    localparam int         IDLE_LIMIT = 20 * (DEPTH + 8);
    localparam int         PHASES     = 12;
    localparam int         PHASE_ITEMS = 110;

    typedef struct {
        bit          is_cfg;
        logic [31:0] cfg_data;
        bpq_in_t     item;
        bit          typed;
        bpq_out_t    res;
    } stim_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    bpq_in_t     in_item  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    bpq_out_t    out_item;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    entry_t      held_entries[$];
    logic [4:0]  capacity_reg = CAPACITY_RESET;

    bpq_out_t    results_due[$];
    bpq_out_t    oldest_due;
    stim_row_t   directed_rows[$];
    int          errors     = 0;
    int          gap_pct    = 0;
    int          stall_pct  = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    bounded_priority_queue #(.DEPTH(DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int effective_capacity();
        if (capacity_reg == 5'd0)
            return 1;
        if (int'(capacity_reg) > DEPTH)
            return DEPTH;
        return int'(capacity_reg);
    endfunction

    // Apply one operation to the held entries and return its status item.
    function automatic bpq_out_t serve_op(bpq_in_t it);
        bpq_out_t r;
        entry_t   e;
        int       best;
        int       cap;
        r   = '0;
        cap = effective_capacity();
        case (it.opcode)
            OP_PUSH:
            begin
                if (held_entries.size() < cap)
                begin
                    e.value = it.push_value;
                    e.prio  = it.push_priority;
                    held_entries.push_back(e);
                    r.ok = 1'b1;
                end
            end
            OP_POP:
            begin
                if (held_entries.size() > 0)
                begin
                    best = 0;
                    // strict compare keeps the earliest arrival among equal priorities
                    for (int i = 1; i < held_entries.size(); i++)
                        if ($signed(held_entries[best].prio) < $signed(held_entries[i].prio))
                            best = i;
                    r.popped_value    = held_entries[best].value;
                    r.popped_priority = held_entries[best].prio;
                    held_entries.delete(best);
                    r.ok = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                held_entries.delete();
                r.ok = 1'b1;
            end
            default:
                r.ok = 1'b0;
        endcase
        r.entry_count = 5'(held_entries.size());
        r.is_empty    = (held_entries.size() == 0);
        r.is_full     = (held_entries.size() >= cap);
        return r;
    endfunction

    function automatic bpq_in_t mk_item(logic [1:0] op, logic [31:0] v, logic [31:0] p);
        bpq_in_t it;
        it.opcode        = op;
        it.push_value    = v;
        it.push_priority = p;
        return it;
    endfunction

    function automatic bpq_out_t mk_res(bit ok, logic [31:0] v, logic [31:0] p,
                                        int cnt, bit emp, bit full);
        bpq_out_t r;
        r.ok              = ok;
        r.popped_value    = v;
        r.popped_priority = p;
        r.entry_count     = 5'(cnt);
        r.is_empty        = emp;
        r.is_full         = full;
        return r;
    endfunction

    function automatic stim_row_t op_row(bpq_in_t it, bit typed, bpq_out_t r);
        stim_row_t row;
        row.is_cfg   = 1'b0;
        row.cfg_data = '0;
        row.item     = it;
        row.typed    = typed;
        row.res      = r;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [31:0] d);
        stim_row_t row;
        row.is_cfg   = 1'b1;
        row.cfg_data = d;
        row.item     = '0;
        row.typed    = 1'b0;
        row.res      = '0;
        return row;
    endfunction

    function automatic bpq_in_t random_item(int push_pct);
        bpq_in_t it;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            it.opcode = OP_PUSH;
        else if (pick < 96)
            it.opcode = OP_POP;
        else if (pick < 98)
            it.opcode = OP_CLEAR;
        else
            it.opcode = OP_UNUSED;
        it.push_value = $urandom;
        case ($urandom_range(0, 3))
            0: it.push_priority = $urandom;
            1: it.push_priority = 32'(int'($urandom_range(0, 7)) - 4);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: it.push_priority = 32'h7FFF_FFFF;
                    1: it.push_priority = 32'h8000_0000;
                    2: it.push_priority = 32'h0;
                    default: it.push_priority = 32'hFFFF_FFFF;
                endcase
            end
            default: it.push_priority = 32'($urandom_range(0, 15));
        endcase
        return it;
    endfunction

    task automatic send_item(input bpq_in_t it, input bit typed, input bpq_out_t typed_res);
        bpq_out_t r;
        int       gap;
        @(negedge clk);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = serve_op(it);
        results_due.push_back(typed ? typed_res : r);
    endtask

    // Drain all results and let the block go quiet before a register write.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == CAP_ADDR)
            capacity_reg = data[4:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic compare_result(input bpq_out_t want, input bpq_out_t got);
        if (got.ok !== want.ok)
        begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            errors++;
        end
        if (got.popped_value !== want.popped_value)
        begin
            $error("popped_value: expected %0d, got %0d", want.popped_value, got.popped_value);
            errors++;
        end
        if (got.popped_priority !== want.popped_priority)
        begin
            $error("popped_priority: expected %0d, got %0d",
                   want.popped_priority, got.popped_priority);
            errors++;
        end
        if (got.entry_count !== want.entry_count)
        begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            errors++;
        end
        if (got.is_empty !== want.is_empty)
        begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            errors++;
        end
        if (got.is_full !== want.is_full)
        begin
            $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("result item with no item outstanding");
                errors++;
            end
            else
            begin
                oldest_due = results_due.pop_front();
                compare_result(oldest_due, out_item);
            end
        end
    end

    // Random result back-pressure in bursts.
    always @(negedge clk)
    begin
        if (!rst_n || stall_pct == 0)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pwrite && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("bounded_priority_queue: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int cap_plan[PHASES] = '{16, 1, 0, 31, 2, -1, 15, 17, -1, 4, -1, 16};
        int cap;
        int push_pct;
        logic [31:0] cfg_word;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // after reset, capacity 16
        directed_rows.push_back(op_row(mk_item(OP_POP, 0, 0), 1, mk_res(0, 0, 0, 0, 1, 0)));
        directed_rows.push_back(op_row(mk_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                                       mk_res(0, 0, 0, 0, 1, 0)));
        directed_rows.push_back(op_row(mk_item(OP_CLEAR, 0, 0), 1, mk_res(1, 0, 0, 0, 1, 0)));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, 32'h7FFF_FFFF, 32'h8000_0000), 1,
                                       mk_res(1, 0, 0, 1, 0, 0)));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, 32'h8000_0000, 32'h7FFF_FFFF), 1,
                                       mk_res(1, 0, 0, 2, 0, 0)));
        // equal top priority, later arrival
        directed_rows.push_back(op_row(mk_item(OP_PUSH, 32'hFFFF_FFFF, 32'h7FFF_FFFF), 1,
                                       mk_res(1, 0, 0, 3, 0, 0)));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, 0, 0), 1, mk_res(1, 0, 0, 4, 0, 0)));
        directed_rows.push_back(op_row(mk_item(OP_UNUSED, $urandom, $urandom), 0, '0));
        directed_rows.push_back(op_row(mk_item(OP_POP, 0, 0), 1,
                                       mk_res(1, 32'h8000_0000, 32'h7FFF_FFFF, 3, 0, 0)));
        directed_rows.push_back(op_row(mk_item(OP_POP, 0, 0), 1,
                                       mk_res(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 2, 0, 0)));
        directed_rows.push_back(op_row(mk_item(OP_POP, 0, 0), 1, mk_res(1, 0, 0, 1, 0, 0)));
        directed_rows.push_back(op_row(mk_item(OP_POP, 0, 0), 1,
                                       mk_res(1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0)));
        directed_rows.push_back(op_row(mk_item(OP_POP, 0, 0), 1, mk_res(0, 0, 0, 0, 1, 0)));
        // smallest capacity: second push is dropped
        directed_rows.push_back(cfg_row(32'd1));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, $urandom, $urandom), 0, '0));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, $urandom, $urandom), 0, '0));
        // zero capacity acts as one
        directed_rows.push_back(cfg_row(32'd0));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, $urandom, $urandom), 0, '0));
        directed_rows.push_back(cfg_row(32'd2));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, $urandom, $urandom), 0, '0));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, $urandom, $urandom), 0, '0));
        // capacity lowered below the fill level
        directed_rows.push_back(cfg_row(32'd1));
        directed_rows.push_back(op_row(mk_item(OP_PUSH, $urandom, $urandom), 0, '0));
        directed_rows.push_back(op_row(mk_item(OP_POP, 0, 0), 0, '0));
        directed_rows.push_back(op_row(mk_item(OP_CLEAR, 0, 0), 1, mk_res(1, 0, 0, 0, 1, 0)));
        // above the built depth acts as the depth
        directed_rows.push_back(cfg_row(32'd31));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                settle();
                write_reg(CAP_ADDR, directed_rows[i].cfg_data);
            end
            else
                send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            cap = (cap_plan[ph] < 0) ? $urandom_range(1, 31) : cap_plan[ph];
            cfg_word = 32'(cap);
            if (ph % 2 == 1)
                cfg_word[31:5] = 27'($urandom);
            write_reg(CAP_ADDR, cfg_word);
            if (ph % 4 == 2)
                write_reg(SPARE_ADDR, $urandom);
            if (ph == PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(10, 40);
                stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(10, 40);
            end
            push_pct = $urandom_range(40, 80);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item(push_pct), 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("bounded_priority_queue: match");
        else
            $display("bounded_priority_queue: mismatch");
        $finish;
    end

endmodule
